>>> design/xbc_pkg.sv
// Shared types, constants and helper functions for the XOR-keyed Base64 codec.
// No dependencies; xbc_regs, xbc_core, xbc_serializer and the top level import it.

package xbc_pkg;

  localparam int KEY_MAX = 8;
  localparam int ADDR_W  = 5;

  // Register indexes, taken from paddr[4:3].
  localparam logic [1:0] REG_MODE      = 2'd0;
  localparam logic [1:0] REG_KEY_LEN   = 2'd1;
  localparam logic [1:0] REG_KEY_BYTES = 2'd2;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  localparam logic [7:0] CH_PAD   = 8'h3D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef struct packed {
    logic        mode;
    logic [3:0]  key_length;
    logic [63:0] key_bytes;
  } cfg_t;

  // Up to four result bytes produced by one item.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    logic            eom;
    logic            err;
  } pkt_t;

  function automatic logic [3:0] key_len_eff(logic [3:0] len);
    return (len > 4'(KEY_MAX)) ? 4'(KEY_MAX) : len;
  endfunction

  function automatic logic [2:0] key_pick(logic [2:0] idx, logic [3:0] len);
    return ({1'b0, idx} >= len) ? 3'd0 : idx;
  endfunction

  function automatic logic [2:0] key_after(logic [2:0] cur_idx, logic [3:0] len);
    logic [3:0] n;
    n = {1'b0, cur_idx} + 4'd1;
    return (n >= len) ? 3'd0 : n[2:0];
  endfunction

  function automatic logic [7:0] key_byte(logic [63:0] kb, logic [2:0] idx);
    return kb[{idx, 3'b000} +: 8];
  endfunction

  function automatic logic [7:0] sextet_char(logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (v < 6'd26) begin
      return CH_UP_A + w;
    end else if (v < 6'd52) begin
      return CH_LO_A + w - 8'd26;
    end else if (v < 6'd62) begin
      return CH_ZERO + w - 8'd52;
    end else if (v == 6'd62) begin
      return CH_PLUS;
    end else begin
      return CH_SLASH;
    end
  endfunction

  // Bit 6 set means the code is outside the alphabet.
  function automatic logic [6:0] char_sextet(logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c >= CH_UP_A && c <= CH_UP_Z) begin
      d = c - CH_UP_A;
      return {1'b0, d[5:0]};
    end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
      d = c - CH_LO_A + 8'd26;
      return {1'b0, d[5:0]};
    end else if (c >= CH_ZERO && c <= CH_NINE) begin
      d = c - CH_ZERO + 8'd52;
      return {1'b0, d[5:0]};
    end else if (c == CH_PLUS) begin
      return 7'd62;
    end else if (c == CH_SLASH) begin
      return 7'd63;
    end else begin
      return 7'h40;
    end
  endfunction

endpackage

>>> design/xbc_ifs.sv
// Valid/ready stream interfaces for the codec's input and result channels.
// No dependencies.

interface xbc_feed_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       message_end;

  modport source (output valid, output data_byte, output message_end, input ready);
  modport sink   (input valid, input data_byte, input message_end, output ready);
endinterface

interface xbc_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       end_of_message;
  logic       error;

  modport source (output valid, output out_byte, output run_last, output end_of_message,
                  output error, input ready);
  modport sink   (input valid, input out_byte, input run_last, input end_of_message,
                  input error, output ready);
endinterface

>>> design/xbc_regs.sv
// APB-style configuration registers: mode, key length and key bytes.
// Depends on xbc_pkg.

module xbc_regs
  import xbc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready,
  output cfg_t              cfg,
  output logic              clear
);

  logic        wr;
  logic [1:0]  reg_idx;
  logic        mode;
  logic [3:0]  key_length;
  logic [63:0] key_bytes;

  assign reg_idx = paddr[4:3];
  assign wr      = psel && penable && pwrite;
  assign pready  = 1'b1;
  // Any write to the mode register aborts the message in progress.
  assign clear   = wr && (reg_idx == REG_MODE);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_ENCODE;
      key_length <= 4'd0;
      key_bytes  <= 64'd0;
    end else if (wr) begin
      unique case (reg_idx)
        REG_MODE:      mode       <= pwdata[0];
        REG_KEY_LEN:   key_length <= pwdata[3:0];
        REG_KEY_BYTES: key_bytes  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MODE:      prdata = {63'd0, mode};
      REG_KEY_LEN:   prdata = {60'd0, key_length};
      REG_KEY_BYTES: prdata = key_bytes;
      default:       prdata = 64'd0;
    endcase
  end

  assign cfg = '{mode: mode, key_length: key_length, key_bytes: key_bytes};

endmodule

>>> design/xbc_core.sv
// Codec datapath: message state, key sequencing and the per-item result group.
// Depends on xbc_pkg. Feeds xbc_serializer through a one-entry result register.

module xbc_core
  import xbc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       clear,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       message_end,
  output logic       res_valid,
  output pkt_t       res,
  input  logic       res_ready
);

  logic [23:0] group_bits, group_bits_next;
  logic [1:0]  group_position, group_position_next;
  logic [2:0]  key_index, key_index_next;
  logic [1:0]  pad_count, pad_count_next;
  logic        bad_char_seen, bad_char_seen_next;

  logic        in_fire;
  logic        has_out;
  pkt_t        pkt;
  logic [3:0]  len;
  logic [2:0]  u0, u1, u2, n0, n1, n2;
  logic [7:0]  k0, k1, k2;
  logic [23:0] gb;
  logic [1:0]  pos, pos_inc, pad;
  logic [7:0]  xb;
  logic [5:0]  v;
  logic [6:0]  sx;
  logic        bad;

  // The result register can take a new group in the cycle its old one moves on.
  assign in_ready = !res_valid || res_ready;
  assign in_fire  = in_valid && in_ready;

  // Three chained key steps cover the most key bytes any item can use.
  always_comb begin
    len = key_len_eff(cfg.key_length);
    u0  = key_pick(key_index, len);
    n0  = key_after(u0, len);
    u1  = key_pick(n0, len);
    n1  = key_after(u1, len);
    u2  = key_pick(n1, len);
    n2  = key_after(u2, len);
    k0  = (len == 4'd0) ? 8'd0 : key_byte(cfg.key_bytes, u0);
    k1  = (len == 4'd0) ? 8'd0 : key_byte(cfg.key_bytes, u1);
    k2  = (len == 4'd0) ? 8'd0 : key_byte(cfg.key_bytes, u2);
  end

  always_comb begin
    group_bits_next     = group_bits;
    group_position_next = group_position;
    key_index_next      = key_index;
    pad_count_next      = pad_count;
    bad_char_seen_next  = bad_char_seen;
    pkt                 = '0;
    has_out             = 1'b0;
    gb                  = group_bits;
    pos                 = 2'd0;
    pos_inc             = 2'd0;
    pad                 = pad_count;
    bad                 = bad_char_seen;
    xb                  = 8'd0;
    v                   = 6'd0;
    sx                  = char_sextet(data_byte);

    if (cfg.mode == MODE_ENCODE) begin
      pos = (group_position > 2'd2) ? 2'd2 : group_position;
      xb  = data_byte ^ k0;
      unique case (pos)
        2'd0:    gb[23:16] = gb[23:16] | xb;
        2'd1:    gb[15:8]  = gb[15:8]  | xb;
        default: gb[7:0]   = gb[7:0]   | xb;
      endcase
      pos_inc = pos + 2'd1;
      if (len != 4'd0) begin
        key_index_next = n0;
      end
      if (pos_inc == 2'd3 || message_end) begin
        has_out      = 1'b1;
        pkt.last_idx = 2'd3;
        for (int i = 0; i < 4; i++) begin
          pkt.bytes[i] = (3'(i) <= {1'b0, pos_inc}) ? sextet_char(gb[23 - 6*i -: 6]) : CH_PAD;
        end
        group_bits_next     = 24'd0;
        group_position_next = 2'd0;
      end else begin
        group_bits_next     = gb;
        group_position_next = pos_inc;
      end
    end else begin
      if (data_byte == CH_PAD) begin
        v = 6'd0;
        if (group_position >= 2'd2) begin
          pad = pad_count + 2'd1;
        end
      end else if (sx[6]) begin
        bad = 1'b1;
        v   = 6'd0;
      end else begin
        v = sx[5:0];
      end
      unique case (group_position)
        2'd0:    gb[23:18] = gb[23:18] | v;
        2'd1:    gb[17:12] = gb[17:12] | v;
        2'd2:    gb[11:6]  = gb[11:6]  | v;
        default: gb[5:0]   = gb[5:0]   | v;
      endcase
      bad_char_seen_next = bad;
      if (group_position == 2'd3) begin
        has_out = 1'b1;
        // Trailing pads drop bytes only in the final group of a message.
        if (message_end) begin
          pkt.last_idx = (pad >= 2'd2) ? 2'd0 : ((pad == 2'd1) ? 2'd1 : 2'd2);
        end else begin
          pkt.last_idx = 2'd2;
        end
        pkt.bytes[0] = gb[23:16] ^ k0;
        pkt.bytes[1] = gb[15:8]  ^ k1;
        pkt.bytes[2] = gb[7:0]   ^ k2;
        pkt.err      = bad;
        if (len != 4'd0) begin
          key_index_next = (pkt.last_idx == 2'd0) ? n0 : ((pkt.last_idx == 2'd1) ? n1 : n2);
        end
        group_bits_next     = 24'd0;
        pad_count_next      = 2'd0;
        group_position_next = 2'd0;
      end else begin
        group_bits_next     = gb;
        pad_count_next      = pad;
        group_position_next = group_position + 2'd1;
        if (message_end) begin
          // Message ended inside a group: one error result.
          has_out = 1'b1;
          pkt.err = 1'b1;
        end
      end
    end

    pkt.eom = message_end;
    if (message_end) begin
      group_bits_next     = 24'd0;
      group_position_next = 2'd0;
      key_index_next      = 3'd0;
      pad_count_next      = 2'd0;
      bad_char_seen_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      group_bits     <= 24'd0;
      group_position <= 2'd0;
      key_index      <= 3'd0;
      pad_count      <= 2'd0;
      bad_char_seen  <= 1'b0;
    end else if (in_fire) begin
      group_bits     <= group_bits_next;
      group_position <= group_position_next;
      key_index      <= key_index_next;
      pad_count      <= pad_count_next;
      bad_char_seen  <= bad_char_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (in_fire && has_out) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && has_out) begin
      res <= pkt;
    end
  end

endmodule

>>> design/xbc_serializer.sv
// Output stage: holds one result group and sends its bytes one per cycle while out_ready is high.
// Depends on xbc_pkg; takes groups from xbc_core.

module xbc_serializer
  import xbc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       res_valid,
  input  pkt_t       res,
  output logic       res_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       run_last,
  output logic       end_of_message,
  output logic       error
);

  pkt_t       cur;
  logic       cur_valid;
  logic [1:0] idx;
  logic       on_last;
  logic       out_fire;

  assign on_last   = (idx == cur.last_idx);
  assign out_fire  = cur_valid && out_ready;
  assign res_ready = !cur_valid || (out_fire && on_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (res_valid && res_ready) begin
      cur_valid <= 1'b1;
      idx       <= 2'd0;
    end else if (out_fire) begin
      if (on_last) begin
        cur_valid <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      cur <= res;
    end
  end

  assign out_valid      = cur_valid;
  assign out_byte       = cur.bytes[idx];
  assign run_last       = on_last;
  assign end_of_message = on_last && cur.eom;
  assign error          = cur.err;

endmodule

>>> design/xor_base64_codec_unit.sv
// XOR-keyed Base64 codec, top level. Ties the register port, the datapath
// and the output stage together. Depends on xbc_pkg, xbc_ifs, xbc_regs,
// xbc_core and xbc_serializer.
//
// The block streams one message at a time. In encode mode every plaintext item
// is XORed with a repeating key of up to eight bytes, and each group of three
// bytes leaves as four Base64 characters (a short final group is padded with
// '='); in decode mode groups of four characters return up to three key-XORed
// bytes, and an error flag marks bad characters and a message that ends inside
// a group. An accepted item is finished by combinational logic and its results
// (zero to four bytes) land in a one-entry result register; the output stage
// takes that group from there once it is free and drains it one byte per cycle
// while the result side is ready. The input stays ready while the result
// register is empty or is handing its group to the output stage, so items that
// cause no result (the first two bytes of an encode group, the first three
// characters of a decode group) enter back to back, and new items are taken
// while the output stage still drains an earlier group. Configuration is
// written over an APB-style port with 64-bit data (mode at 0x00, key length at
// 0x08, key bytes at 0x10, first key byte lowest); pready is always high. Write
// mode, which also aborts any message in progress, and the key only while no
// items are in flight. Key lengths above eight act as eight and a length of
// zero turns the XOR off. The key restarts at its first byte with every new
// message.

module xor_base64_codec_unit
  import xbc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  xbc_feed_if.sink          feed,
  xbc_result_if.source      result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready
);

  cfg_t cfg;
  logic clear;
  logic res_valid;
  logic res_ready;
  pkt_t res;

  xbc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .clear   (clear)
  );

  // All per-item work happens here, in logic ahead of the result register.
  xbc_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .clear       (clear),
    .in_valid    (feed.valid),
    .in_ready    (feed.ready),
    .data_byte   (feed.data_byte),
    .message_end (feed.message_end),
    .res_valid   (res_valid),
    .res         (res),
    .res_ready   (res_ready)
  );

  // The output stage takes a new group at the same edge its last byte leaves,
  // so the result register frees up without a bubble.
  xbc_serializer u_serializer (
    .clk            (clk),
    .rst            (rst),
    .res_valid      (res_valid),
    .res            (res),
    .res_ready      (res_ready),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .out_byte       (result.out_byte),
    .run_last       (result.run_last),
    .end_of_message (result.end_of_message),
    .error          (result.error)
  );

endmodule

>>> design/xbc_checker.sv
// Port-level checks for xor_base64_codec_unit, attached with a bind.
// Depends only on the top level's ports.

module xbc_checker (
  input logic       clk,
  input logic       rst,
  input logic       feed_ready,
  input logic       result_valid,
  input logic       result_ready,
  input logic [7:0] out_byte,
  input logic       run_last,
  input logic       end_of_message
);

  // Out of reset the block is empty and ready for an item.
  a_reset_empty: assert property (@(posedge clk) rst |=> (feed_ready && !result_valid))
    else $error("block not empty after reset");

  // A held-off input means a result group is pending, so results must flow next.
  a_busy_drains: assert property (@(posedge clk) disable iff (rst)
    !feed_ready |=> result_valid)
    else $error("input stalled with no result on offer");

  // The final result of a message is always the last result of its item.
  a_eom_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && end_of_message) |-> run_last)
    else $error("end of message without run_last");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=>
      (result_valid && $stable(out_byte) && $stable(run_last) && $stable(end_of_message)))
    else $error("stalled result changed");

endmodule

bind xor_base64_codec_unit xbc_checker u_xbc_checker (
  .clk            (clk),
  .rst            (rst),
  .feed_ready     (feed.ready),
  .result_valid   (result.valid),
  .result_ready   (result.ready),
  .out_byte       (result.out_byte),
  .run_last       (result.run_last),
  .end_of_message (result.end_of_message)
);
